@@ rtl/dwbv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwbv_pkg
// Shared constants and controller/datapath interface types for the bone vote.
// ----------------------------------------------------------------------------
package dwbv_pkg;

    localparam int BONE_COUNT = 256;
    localparam int BONE_W     = $clog2(BONE_COUNT);
    localparam int SLOTS      = 4;
    localparam int SLOT_W     = 2;
    localparam int SUM_WIDTH  = 40;
    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int WGT_W      = 16;
    localparam int CNT_W      = 8;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS  = 17;

    localparam logic [2:0] CFG_QUERY_X = 3'd0;
    localparam logic [2:0] CFG_QUERY_Y = 3'd1;
    localparam logic [2:0] CFG_QUERY_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS  = 3'd3;
    localparam logic [2:0] CFG_MIN_WGT = 3'd4;

    typedef struct packed {
        logic              load_vert;
        logic              diff_load;
        logic              sq_en;
        logic              root_step;
        logic              div_init;
        logic              div_step;
        logic              f_zero;
        logic              slot_rd;
        logic              slot_wr;
        logic [SLOT_W-1:0] slot;
        logic              mem_clr;
        logic              scan_cmp;
        logic              scan_init;
        logic              out_load;
        logic [CNT_W-1:0]  cnt;
    } dwbv_cmd_t;

    typedef struct packed {
        logic far;
        logic d_ge_r;
        logic w_skip;
        logic last;
        logic out_busy;
    } dwbv_stat_t;

endpackage

@@ rtl/dwbv_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwbv_ctrl
// Sequencer for distance, falloff, slot updates, scan and clear.
// ----------------------------------------------------------------------------
module dwbv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dwbv_pkg::dwbv_stat_t stat,
    output dwbv_pkg::dwbv_cmd_t  cmd
);
    import dwbv_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_ROOT = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;
    localparam logic [3:0] S_SCAN = 4'd9;
    localparam logic [3:0] S_TAIL = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        logic slot_done;
        slot_done  = (slot_reg == SLOT_W'(SLOTS - 1));
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        cmd.slot   = slot_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.mem_clr = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BONE_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_vert = 1'b1;
                    state_next    = S_DIFF;
                end
            end
            S_DIFF: begin
                cmd.diff_load = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQ;
            end
            S_SQ: begin
                if (stat.far) begin
                    cmd.f_zero = 1'b1;
                    slot_next  = '0;
                    state_next = S_RD;
                end else begin
                    cmd.sq_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(2)) begin
                        cnt_next   = '0;
                        state_next = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                slot_next = '0;
                cnt_next  = '0;
                if (stat.d_ge_r) begin
                    cmd.f_zero = 1'b1;
                    state_next = S_RD;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (stat.w_skip) begin
                    slot_next = slot_reg + 1'b1;
                    if (slot_done) begin
                        cnt_next = '0;
                        if (stat.last) begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    cmd.slot_rd = 1'b1;
                    state_next  = S_WR;
                end
            end
            S_WR: begin
                cmd.slot_wr = 1'b1;
                slot_next   = slot_reg + 1'b1;
                state_next  = S_RD;
                if (slot_done) begin
                    cnt_next = '0;
                    if (stat.last) begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                cmd.mem_clr  = 1'b1;
                cmd.scan_cmp = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BONE_COUNT - 1)) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

@@ rtl/dwbv_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwbv_dp
// Datapath: config registers, distance root, falloff divide, bone sum store.
// ----------------------------------------------------------------------------
module dwbv_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dwbv_pkg::dwbv_cmd_t  cmd,
    output dwbv_pkg::dwbv_stat_t stat,
    input  logic                 cfg_valid,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [31:0]          s_vert_x,
    input  logic [31:0]          s_vert_y,
    input  logic [31:0]          s_vert_z,
    input  logic [7:0]           s_bone_a,
    input  logic [7:0]           s_bone_b,
    input  logic [7:0]           s_bone_c,
    input  logic [7:0]           s_bone_d,
    input  logic [15:0]          s_weight_a,
    input  logic [15:0]          s_weight_b,
    input  logic [15:0]          s_weight_c,
    input  logic [15:0]          s_weight_d,
    input  logic                 s_last_vertex,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [7:0]           m_best_bone,
    output logic                 m_found,
    output logic [39:0]          m_best_sum
);
    import dwbv_pkg::*;

    logic signed [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [WGT_W-1:0]          minw_reg;

    logic signed [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [BONE_W-1:0]         bone_reg [SLOTS];
    logic [WGT_W-1:0]          wgt_reg  [SLOTS];
    logic                      last_reg;

    logic [COORD_W:0]          ax_reg, ay_reg, az_reg;
    logic [63:0]               n_reg, res_reg, bit_reg;
    logic [32:0]               rem_reg;
    logic [DIV_STEPS-1:0]      q_reg;
    logic [WGT_W-1:0]          add_reg;

    logic [SUM_WIDTH-1:0]      mem [BONE_COUNT];
    logic [SUM_WIDTH-1:0]      rd_data_reg;
    logic                      scan_vld_reg;
    logic [BONE_W-1:0]         scan_idx_reg;
    logic [BONE_W-1:0]         best_bone_reg;
    logic [SUM_WIDTH-1:0]      best_sum_reg;
    logic                      found_reg;
    logic                      m_valid_reg;

    function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? (COORD_W+1)'(-d) : d;
    endfunction

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg   <= '0;
            qy_reg   <= '0;
            qz_reg   <= '0;
            rad_reg  <= RAD_W'(65536);
            minw_reg <= WGT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUERY_X: qx_reg   <= cfg_data;
                CFG_QUERY_Y: qy_reg   <= cfg_data;
                CFG_QUERY_Z: qz_reg   <= cfg_data;
                CFG_RADIUS:  rad_reg  <= cfg_data[RAD_W-1:0];
                CFG_MIN_WGT: minw_reg <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // falloff arithmetic
    logic [63:0]          sq_op;
    logic [30:0]          sq_in;
    logic [63:0]          trial;
    logic [31:0]          d_root;
    logic [32:0]          rad_ext;
    logic [WGT_W-1:0]     falloff;
    logic [SUM_WIDTH:0]   sum_wide;
    logic [BONE_W-1:0]    mem_addr;

    always_comb begin
        case (cmd.cnt[1:0])
            2'd0:    sq_in = ax_reg[30:0];
            2'd1:    sq_in = ay_reg[30:0];
            default: sq_in = az_reg[30:0];
        endcase
    end

    assign sq_op   = 64'(sq_in) * 64'(sq_in);
    assign trial   = res_reg + bit_reg;
    assign d_root  = res_reg[31:0];
    assign rad_ext = {2'b00, rad_reg};
    assign falloff = q_reg[DIV_STEPS-1] ? '1 : q_reg[WGT_W-1:0];
    assign sum_wide = {1'b0, rd_data_reg} + (SUM_WIDTH+1)'(add_reg);
    assign mem_addr = cmd.mem_clr ? cmd.cnt[BONE_W-1:0] : bone_reg[cmd.slot];

    assign stat.far      = (ax_reg >= rad_ext) || (ay_reg >= rad_ext) || (az_reg >= rad_ext);
    assign stat.d_ge_r   = ({1'b0, d_root} >= rad_ext);
    assign stat.w_skip   = (wgt_reg[cmd.slot] < minw_reg);
    assign stat.last     = last_reg;
    assign stat.out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_vert) begin
            vx_reg      <= s_vert_x;
            vy_reg      <= s_vert_y;
            vz_reg      <= s_vert_z;
            bone_reg[0] <= s_bone_a;
            bone_reg[1] <= s_bone_b;
            bone_reg[2] <= s_bone_c;
            bone_reg[3] <= s_bone_d;
            wgt_reg[0]  <= s_weight_a;
            wgt_reg[1]  <= s_weight_b;
            wgt_reg[2]  <= s_weight_c;
            wgt_reg[3]  <= s_weight_d;
            last_reg    <= s_last_vertex;
        end
        if (cmd.diff_load) begin
            ax_reg  <= abs_diff(vx_reg, qx_reg);
            ay_reg  <= abs_diff(vy_reg, qy_reg);
            az_reg  <= abs_diff(vz_reg, qz_reg);
            n_reg   <= '0;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        if (cmd.sq_en) begin
            n_reg <= n_reg + sq_op;
        end
        if (cmd.root_step) begin
            if (n_reg >= trial) begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.f_zero) begin
            q_reg <= '0;
        end
        if (cmd.div_init) begin
            rem_reg <= {1'b0, 32'(rad_reg) - d_root};
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (rem_reg >= rad_ext) begin
                q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b1};
                rem_reg <= (rem_reg - rad_ext) << 1;
            end else begin
                q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b0};
                rem_reg <= rem_reg << 1;
            end
        end
        if (cmd.slot_rd) begin
            add_reg <= WGT_W'((32'(wgt_reg[cmd.slot]) * 32'(falloff)) >> 16);
        end
    end

    // bone sum store: read old data, write new or zero
    always_ff @(posedge aclk) begin
        if (cmd.mem_clr) begin
            mem[mem_addr] <= '0;
        end else if (cmd.slot_wr) begin
            mem[mem_addr] <= sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
        end
        rd_data_reg <= mem[mem_addr];
    end

    // scan for the lowest-index maximum above the threshold
    logic [SUM_WIDTH-1:0] scan_bar;
    assign scan_bar = found_reg ? best_sum_reg : SUM_WIDTH'(minw_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            scan_vld_reg <= cmd.scan_cmp;
            if (cmd.scan_init) begin
                found_reg <= 1'b0;
            end else if (scan_vld_reg && rd_data_reg > scan_bar) begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= cmd.cnt[BONE_W-1:0];
        if (cmd.scan_init) begin
            best_bone_reg <= '0;
            best_sum_reg  <= '0;
        end else if (scan_vld_reg && rd_data_reg > scan_bar) begin
            best_bone_reg <= scan_idx_reg;
            best_sum_reg  <= rd_data_reg;
        end
        if (cmd.out_load) begin
            m_best_bone <= best_bone_reg;
            m_found     <= found_reg;
            m_best_sum  <= best_sum_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/distance_weighted_bone_vote_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_weighted_bone_vote_top
// Distance-weighted bone vote over skinned vertices with a 256-entry sum store.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid/s_ready, vertex position, bones, weights, last
//  m_      | out       | m_valid/m_ready, best bone, found, best sum
//  cfg_    | in        | cfg_valid/cfg_ready, cfg_index, cfg_data
//
//  A vertex is loaded and its differences formed; if a component is outside
//  the radius it goes to the slots, else it takes 3 squares, 32 root steps,
//  1 check, and 17 divide steps when d < R; each used slot is then read and
//  written, each skipped one passed over. The last vertex adds a scan of the
//  store, which clears it. After reset a pass clears all 256 entries before
//  s_ready rises. A pending result holds the scan end until m_ready takes it.
// ----------------------------------------------------------------------------
module distance_weighted_bone_vote_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_vert_x,
    input  logic [31:0] s_vert_y,
    input  logic [31:0] s_vert_z,
    input  logic [7:0]  s_bone_a,
    input  logic [7:0]  s_bone_b,
    input  logic [7:0]  s_bone_c,
    input  logic [7:0]  s_bone_d,
    input  logic [15:0] s_weight_a,
    input  logic [15:0] s_weight_b,
    input  logic [15:0] s_weight_c,
    input  logic [15:0] s_weight_d,
    input  logic        s_last_vertex,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_best_bone,
    output logic        m_found,
    output logic [39:0] m_best_sum
);
    import dwbv_pkg::*;

    dwbv_cmd_t  cmd;
    dwbv_stat_t stat;

    assign cfg_ready = 1'b1;

    dwbv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dwbv_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_vert_x      (s_vert_x),
        .s_vert_y      (s_vert_y),
        .s_vert_z      (s_vert_z),
        .s_bone_a      (s_bone_a),
        .s_bone_b      (s_bone_b),
        .s_bone_c      (s_bone_c),
        .s_bone_d      (s_bone_d),
        .s_weight_a    (s_weight_a),
        .s_weight_b    (s_weight_b),
        .s_weight_c    (s_weight_c),
        .s_weight_d    (s_weight_d),
        .s_last_vertex (s_last_vertex),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_best_bone   (m_best_bone),
        .m_found       (m_found),
        .m_best_sum    (m_best_sum)
    );

`ifndef SYNTHESIS
    a_no_output_during_work : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("result loaded over a pending one");

    a_not_found_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_best_sum == '0 && m_best_bone == '0))
        else $error("no winner but nonzero result");

    a_ready_after_load : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while busy");
`endif

endmodule
